@@ rtl/bfa_pkg.sv @@
// Shared types and constants of the bitmap frame allocator.
// Depends on nothing; every other file of the block imports it.
package bfa_pkg;

    localparam int unsigned BFA_MAX_FRAMES = 4096;

    // map memory word: one bit per frame, 1 = used
    localparam int unsigned WORD_W = 64;
    localparam int unsigned BIT_W  = $clog2(WORD_W);

    // command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_USABLE_FRAMES = 1'b1;

    // segment finder result for one map word
    typedef struct packed {
        logic             u_hit;  // a used (or out of range) bit at or above lo
        logic [BIT_W-1:0] u_idx;  // lowest such bit
        logic             f_hit;  // a free bit above u_idx
        logic [BIT_W-1:0] f_idx;  // lowest such bit
    } t_seg;

endpackage

@@ rtl/bfa_req_if.sv @@
// Request channel of the frame allocator: command, count and first frame.
// Depends on bfa_pkg.
interface bfa_req_if import bfa_pkg::*; #(
    parameter int unsigned MAX_FRAMES = BFA_MAX_FRAMES
) ();
    localparam int unsigned FRAME_W = $clog2(MAX_FRAMES);
    localparam int unsigned CNT_W   = $clog2(MAX_FRAMES + 1);

    logic               valid;
    logic               ready;
    logic               cmd;
    logic [CNT_W-1:0]   count;
    logic [FRAME_W-1:0] frame_index;

    modport source (output valid, cmd, count, frame_index, input ready);
    modport sink   (input valid, cmd, count, frame_index, output ready);
endinterface

@@ rtl/bfa_rsp_if.sv @@
// Response channel of the frame allocator: status, run start and counters.
// Depends on bfa_pkg.
interface bfa_rsp_if import bfa_pkg::*; #(
    parameter int unsigned MAX_FRAMES = BFA_MAX_FRAMES
) ();
    localparam int unsigned FRAME_W = $clog2(MAX_FRAMES);
    localparam int unsigned CNT_W   = $clog2(MAX_FRAMES + 1);

    logic                   valid;
    logic                   ready;
    logic                   ok;
    logic [FRAME_W-1:0]     frame_start;
    logic [CNT_W-1:0]       free_count;
    logic signed [CNT_W:0]  used_count;

    modport source (output valid, ok, frame_start, free_count, used_count, input ready);
    modport sink   (input valid, ok, frame_start, free_count, used_count, output ready);
endinterface

@@ rtl/bfa_seg_find.sv @@
// Segment finder: from a start bit, locates the end of the free stretch and
// the next free bit in one map word. Depends on bfa_pkg.
module bfa_seg_find import bfa_pkg::*; (
    input  logic [WORD_W-1:0] i_data,
    input  logic [BIT_W-1:0]  i_lo,
    input  logic              i_last,
    input  logic [BIT_W-1:0]  i_lb,
    output t_seg              o_seg
);

    logic [WORD_W-1:0] in_range;
    logic [WORD_W-1:0] used_c;
    logic [WORD_W-1:0] free_c;
    logic              u_hit;
    logic [BIT_W-1:0]  u_idx;
    logic              f_hit;
    logic [BIT_W-1:0]  f_idx;

    // bits past the end of the map count as used
    always_comb begin
        for (int b = 0; b < WORD_W; b++) begin
            in_range[b] = !i_last || (BIT_W'(b) <= i_lb);
            used_c[b]   = (i_data[b] | ~in_range[b]) & (BIT_W'(b) >= i_lo);
        end
    end

    always_comb begin
        u_hit = 1'b0;
        u_idx = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (used_c[b]) begin
                u_hit = 1'b1;
                u_idx = BIT_W'(b);
            end
        end
    end

    always_comb begin
        for (int b = 0; b < WORD_W; b++) begin
            free_c[b] = ~i_data[b] & in_range[b] & u_hit & (BIT_W'(b) > u_idx);
        end
    end

    always_comb begin
        f_hit = 1'b0;
        f_idx = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (free_c[b]) begin
                f_hit = 1'b1;
                f_idx = BIT_W'(b);
            end
        end
    end

    assign o_seg = {u_hit, u_idx, f_hit, f_idx};

endmodule

@@ rtl/bitmap_frame_allocator_core.sv @@
// Bitmap frame allocator: a used map with one bit per frame held in a
// 64-bit-wide single-port-read memory, a free count and a next-fit hint.
// After reset the block fills the map with ones (every frame used), one word
// per cycle, and takes no request until that pass ends. An allocate that
// fails the count check, and a free of zero frames or from a first frame past
// the map, go straight to the response state. An allocate scans from the hint
// one map word per cycle, staying on a word to restart at each used gap met
// inside it, for at most two passes over the map, then marks the run one word
// per cycle. A free clears its frames word by word in the same way.
// The single segment finder and the one read port of the map set this pace.
// One request is worked on at a time; the response register lets the next
// request in while a response waits.
// Depends on bfa_pkg, bfa_req_if, bfa_rsp_if and bfa_seg_find.
module bitmap_frame_allocator_core import bfa_pkg::*; #(
    parameter int unsigned MAX_FRAMES = BFA_MAX_FRAMES,
    localparam int unsigned CNT_W     = $clog2(MAX_FRAMES + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CNT_W-1:0]     i_cfg_data,
    bfa_req_if.sink              i_req,
    bfa_rsp_if.source            o_rsp
);

    localparam int unsigned FRAME_W = $clog2(MAX_FRAMES);
    localparam int unsigned NWORDS  = (MAX_FRAMES + WORD_W - 1) / WORD_W;
    localparam int unsigned WI_W    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int unsigned POS_W   = WI_W + BIT_W;

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_SRD  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_MRD  = 3'd4;
    localparam logic [2:0] S_MOD  = 3'd5;
    localparam logic [2:0] S_RESP = 3'd6;

    // control state
    logic [2:0]         r_state;
    logic [WI_W-1:0]    r_init_cnt;
    logic [CNT_W-1:0]   r_frames_cfg;
    logic [CNT_W-1:0]   r_usable;
    logic [CNT_W-1:0]   r_free_total;
    logic [FRAME_W-1:0] r_hint;
    logic               r_o_valid;

    // per-request working registers
    logic               r_cmd;
    logic [CNT_W-1:0]   r_count;
    logic [WI_W-1:0]    r_word;
    logic [BIT_W-1:0]   r_lo;
    logic [CNT_W-1:0]   r_run;
    logic [POS_W-1:0]   r_run_start;
    logic               r_pass;
    logic [CNT_W-1:0]   r_left;
    logic               r_ok;
    logic [FRAME_W-1:0] r_start;

    // response register
    logic               r_o_ok;
    logic [FRAME_W-1:0] r_o_start;
    logic [CNT_W-1:0]   r_o_free;
    logic signed [CNT_W:0] r_o_used;

    // map memory
    logic [WORD_W-1:0]  mem [NWORDS];
    logic [WORD_W-1:0]  r_rdata;
    logic               mem_re;
    logic [WI_W-1:0]    mem_raddr;
    logic               mem_we;
    logic [WI_W-1:0]    mem_waddr;
    logic [WORD_W-1:0]  mem_wdata;

    // map geometry
    logic [CNT_W-1:0]   map_n;
    logic [POS_W-1:0]   last_pos;
    logic [WI_W-1:0]    lw;
    logic [BIT_W-1:0]   lb;
    logic               hint_ok;

    // scan datapath
    t_seg               seg;
    logic [BIT_W:0]     seg_end;
    logic [BIT_W:0]     seg_len;
    logic [CNT_W:0]     run_sum;
    logic [POS_W-1:0]   cand_start;
    logic               found;
    logic               stay_word;
    logic               at_last;

    // mark / clear datapath
    logic [BIT_W:0]     avail;
    logic [BIT_W:0]     take;
    logic [BIT_W:0]     lo_end;
    logic [WORD_W-1:0]  mod_mask;
    logic [BIT_W:0]     cleared;
    logic [CNT_W-1:0]   left_next;
    logic [POS_W:0]     end_sum;

    // request setup
    logic               req_acc;
    logic [CNT_W-1:0]   fi_ext;
    logic [CNT_W-1:0]   fi_avail;
    logic [POS_W-1:0]   fi_pos;
    logic [POS_W-1:0]   hint_pos;

    always_comb begin
        if (r_frames_cfg == '0) begin
            map_n = CNT_W'(1);
        end else if (r_frames_cfg > CNT_W'(MAX_FRAMES)) begin
            map_n = CNT_W'(MAX_FRAMES);
        end else begin
            map_n = r_frames_cfg;
        end
    end

    assign last_pos = POS_W'(FRAME_W'(map_n - CNT_W'(1)));
    assign lw       = last_pos[POS_W-1:BIT_W];
    assign lb       = last_pos[BIT_W-1:0];
    assign hint_ok  = CNT_W'(r_hint) < map_n;
    assign hint_pos = hint_ok ? POS_W'(r_hint) : '0;

    assign req_acc  = i_req.valid && i_req.ready;
    assign fi_ext   = CNT_W'(i_req.frame_index);
    assign fi_avail = map_n - fi_ext;
    assign fi_pos   = POS_W'(i_req.frame_index);

    assign at_last = (r_word == lw);

    bfa_seg_find u_seg_find (
        .i_data (r_rdata),
        .i_lo   (r_lo),
        .i_last (at_last),
        .i_lb   (lb),
        .o_seg  (seg)
    );

    assign seg_end    = seg.u_hit ? {1'b0, seg.u_idx} : (BIT_W+1)'(WORD_W);
    assign seg_len    = seg_end - {1'b0, r_lo};
    assign run_sum    = (CNT_W+1)'(r_run) + (CNT_W+1)'(seg_len);
    assign cand_start = (r_run == '0) ? {r_word, r_lo} : r_run_start;
    assign found      = run_sum >= {1'b0, r_count};
    assign stay_word  = seg.u_hit && seg.f_hit;

    assign avail = (BIT_W+1)'(WORD_W) - {1'b0, r_lo};
    always_comb begin
        if ((CNT_W+BIT_W+1)'(r_left) >= (CNT_W+BIT_W+1)'(avail)) begin
            take = avail;
        end else begin
            take = (BIT_W+1)'(r_left);
        end
    end
    assign lo_end = {1'b0, r_lo} + take;

    always_comb begin
        for (int b = 0; b < WORD_W; b++) begin
            mod_mask[b] = ((BIT_W+1)'(b) >= {1'b0, r_lo}) && ((BIT_W+1)'(b) < lo_end);
        end
    end

    assign cleared   = (BIT_W+1)'($countones(r_rdata & mod_mask));
    assign left_next = r_left - CNT_W'(take);
    assign end_sum   = (POS_W+1)'(r_start) + (POS_W+1)'(r_count);

    // memory port control
    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = r_word;
        mem_we    = 1'b0;
        mem_waddr = r_word;
        mem_wdata = (r_cmd == CMD_ALLOC) ? (r_rdata | mod_mask) : (r_rdata & ~mod_mask);
        case (r_state)
            S_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = r_init_cnt;
                mem_wdata = '1;
            end
            S_SRD, S_MRD: begin
                mem_re = 1'b1;
            end
            S_SCAN: begin
                if (!found && !stay_word) begin
                    if (at_last) begin
                        mem_re    = !r_pass;
                        mem_raddr = '0;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = r_word + WI_W'(1);
                    end
                end
            end
            S_MOD: begin
                mem_we = 1'b1;
                if (left_next != '0) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_word + WI_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames_cfg <= CNT_W'(MAX_FRAMES);
            r_usable     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FRAMES_IN_USE: r_frames_cfg <= i_cfg_data;
                CFG_USABLE_FRAMES: r_usable     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_init_cnt   <= '0;
            r_free_total <= '0;
            r_hint       <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            // in the response state the load below decides the valid flag
            if (o_rsp.valid && o_rsp.ready && (r_state != S_RESP)) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_INIT: begin
                    r_init_cnt <= r_init_cnt + WI_W'(1);
                    if (r_init_cnt == WI_W'(NWORDS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (req_acc) begin
                        r_cmd   <= i_req.cmd;
                        r_count <= i_req.count;
                        r_start <= '0;
                        r_run   <= '0;
                        r_pass  <= 1'b0;
                        if (i_req.cmd == CMD_ALLOC) begin
                            r_ok   <= 1'b0;
                            r_word <= hint_pos[POS_W-1:BIT_W];
                            r_lo   <= hint_pos[BIT_W-1:0];
                            if (i_req.count == '0 || i_req.count > r_free_total) begin
                                r_state <= S_RESP;
                            end else begin
                                r_state <= S_SRD;
                            end
                        end else begin
                            r_ok   <= (i_req.count != '0);
                            r_word <= fi_pos[POS_W-1:BIT_W];
                            r_lo   <= fi_pos[BIT_W-1:0];
                            r_left <= (i_req.count < fi_avail) ? i_req.count : fi_avail;
                            if (i_req.count == '0 || fi_ext >= map_n) begin
                                r_state <= S_RESP;
                            end else begin
                                r_state <= S_MRD;
                            end
                        end
                    end
                end
                S_SRD: begin
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    r_run_start <= cand_start;
                    if (found) begin
                        r_ok    <= 1'b1;
                        r_start <= FRAME_W'(cand_start);
                        r_word  <= cand_start[POS_W-1:BIT_W];
                        r_lo    <= cand_start[BIT_W-1:0];
                        r_left  <= r_count;
                        r_state <= S_MRD;
                    end else if (stay_word) begin
                        // used gap inside the word: restart the run at the next free bit
                        r_run <= '0;
                        r_lo  <= seg.f_idx;
                    end else if (at_last) begin
                        // runs never cross the wrap
                        r_run  <= '0;
                        r_word <= '0;
                        r_lo   <= '0;
                        r_pass <= 1'b1;
                        if (r_pass) begin
                            r_state <= S_RESP;
                        end
                    end else begin
                        r_run  <= seg.u_hit ? '0 : CNT_W'(run_sum);
                        r_word <= r_word + WI_W'(1);
                        r_lo   <= '0;
                    end
                end
                S_MRD: begin
                    if (r_cmd == CMD_ALLOC) begin
                        r_free_total <= r_free_total - r_count;
                        r_hint <= (end_sum == (POS_W+1)'(map_n)) ? '0 : FRAME_W'(end_sum);
                    end
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    if (r_cmd == CMD_FREE) begin
                        r_free_total <= r_free_total + CNT_W'(cleared);
                    end
                    r_left <= left_next;
                    {r_word, r_lo} <= {r_word, r_lo} + POS_W'(take);
                    if (left_next == '0) begin
                        r_state <= S_RESP;
                    end
                end
                S_RESP: begin
                    if (!r_o_valid || o_rsp.ready) begin
                        r_o_valid <= 1'b1;
                        r_o_ok    <= r_ok;
                        r_o_start <= r_start;
                        r_o_free  <= r_free_total;
                        r_o_used  <= signed'((CNT_W+1)'(r_usable) - (CNT_W+1)'(r_free_total));
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_o_valid;
    assign o_rsp.ok          = r_o_ok;
    assign o_rsp.frame_start = r_o_start;
    assign o_rsp.free_count  = r_o_free;
    assign o_rsp.used_count  = r_o_used;

    // a scan never holds a run as long as the request
    a_run_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_run < r_count))
        else $error("scan run length reached request count");

    // the scan never steps past the last map word
    a_word_in_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_word <= lw))
        else $error("scan word beyond end of map");

    // every mark or clear cycle has frames left to touch
    a_mod_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD) |-> (r_left != '0))
        else $error("map update with nothing left");

    // free count tracks clear bits, so it cannot pass the map size
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_total <= CNT_W'(MAX_FRAMES))
        else $error("free count above map size");

    // a response is loaded only on the way back to idle
    a_resp_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_o_valid)) |-> (r_state == S_IDLE) && ($past(r_state) == S_RESP))
        else $error("response loaded outside the response state");

endmodule
